/* hdl/spmt_pkg.sv */
`default_nettype none
package spmt_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned PREFIX_W = 6;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned INDEX_W  = 6;
    localparam int unsigned COUNT_W  = 7;

    localparam logic [PREFIX_W-1:0] PREFIX_MAX = 6'd32;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_LOOKUP = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]   network;
        logic [PREFIX_W-1:0] prefix;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic               found;
        logic               table_full;
        logic [INDEX_W-1:0] match_index;
        t_entry             match;
        logic [COUNT_W-1:0] entry_count;
    } t_result;

endpackage
`default_nettype wire

/* hdl/spmt_cmd_if.sv */
`default_nettype none
interface spmt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [15:0] handle;

    modport source (output valid, output func, output address, output prefix_len,
                    output handle, input ready);
    modport sink (input valid, input func, input address, input prefix_len,
                  input handle, output ready);
endinterface
`default_nettype wire

/* hdl/spmt_rsp_if.sv */
`default_nettype none
interface spmt_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic        table_full;
    logic [5:0]  match_index;
    logic [31:0] match_network;
    logic [5:0]  match_prefix;
    logic [15:0] match_handle;
    logic [6:0]  entry_count;

    modport source (output valid, output found, output table_full, output match_index,
                    output match_network, output match_prefix, output match_handle,
                    output entry_count, input ready);
    modport sink (input valid, input found, input table_full, input match_index,
                  input match_network, input match_prefix, input match_handle,
                  input entry_count, output ready);
endinterface
`default_nettype wire

/* hdl/subnet_prefix_match_table.sv */
// Channel   Direction  Beat carries
// i_cmd     in         func, address, prefix_len, handle
// o_rsp     out        found, table_full, match_index, match_network, match_prefix,
//                      match_handle, entry_count
//
// An add writes its entry, if the table has room, when it is accepted; its result
// passes through S_DONE to the output register. A delete or lookup reads one stored
// entry per cycle through the single RAM read port; a lookup stops at the first match.
// Only one command is in flight, and a new command is accepted while the previous
// result still waits in the output register. Reset empties the table.
`default_nettype none
module subnet_prefix_match_table #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spmt_cmd_if.sink    i_cmd,
    spmt_rsp_if.source  o_rsp
);
    import spmt_pkg::*;

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_rd_idx, n_rd_idx;
    logic [CW-1:0]   r_wr_idx, n_wr_idx;
    logic [IW-1:0]   r_proc_idx, n_proc_idx;
    logic            r_pend, n_pend;
    t_func           r_func, n_func;
    logic [ADDR_W-1:0] r_key, n_key;
    logic            r_found, n_found;
    logic            r_full, n_full;
    logic [IW-1:0]   r_hit_idx, n_hit_idx;
    t_entry          r_hit, n_hit;
    logic            r_out_vld, n_out_vld;
    t_result         r_out, n_out;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    t_entry          ram_wdata;
    logic            ram_re;
    t_entry          ram_rdata;
    logic            hit;
    logic            last;
    t_entry          new_entry;

    spmt_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    spmt_match_unit u_match (
        .i_exact (r_func == FUNC_DELETE),
        .i_key   (r_key),
        .i_entry (ram_rdata),
        .o_hit   (hit)
    );

    assign i_cmd.ready = (r_state == S_IDLE);

    assign new_entry.network = i_cmd.address;
    assign new_entry.prefix  = (i_cmd.prefix_len > PREFIX_MAX) ? PREFIX_MAX
                                                               : i_cmd.prefix_len;
    assign new_entry.handle  = i_cmd.handle;

    assign last = (CW'(r_proc_idx) == (r_count - CW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_wr_idx   <= n_wr_idx;
        r_proc_idx <= n_proc_idx;
        r_func     <= n_func;
        r_key      <= n_key;
        r_found    <= n_found;
        r_full     <= n_full;
        r_hit_idx  <= n_hit_idx;
        r_hit      <= n_hit;
        r_out      <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rd_idx   = r_rd_idx;
        n_wr_idx   = r_wr_idx;
        n_proc_idx = r_proc_idx;
        n_pend     = r_pend;
        n_func     = r_func;
        n_key      = r_key;
        n_found    = r_found;
        n_full     = r_full;
        n_hit_idx  = r_hit_idx;
        n_hit      = r_hit;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !o_rsp.ready;
        ram_we     = 1'b0;
        ram_waddr  = r_wr_idx[IW-1:0];
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_func    = t_func'(i_cmd.func);
                    n_key     = i_cmd.address;
                    n_found   = 1'b0;
                    n_full    = 1'b0;
                    n_hit_idx = '0;
                    n_hit     = '0;
                    n_rd_idx  = '0;
                    n_wr_idx  = '0;
                    n_pend    = 1'b0;
                    n_state   = S_DONE;
                    case (t_func'(i_cmd.func))
                        FUNC_ADD: begin
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_full = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[IW-1:0];
                                ram_wdata = new_entry;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        FUNC_DELETE, FUNC_LOOKUP: begin
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rd_idx < r_count) begin
                    ram_re     = 1'b1;
                    n_rd_idx   = r_rd_idx + CW'(1);
                    n_proc_idx = r_rd_idx[IW-1:0];
                    n_pend     = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_func == FUNC_LOOKUP) begin
                        if (hit) begin
                            n_found   = 1'b1;
                            n_hit_idx = r_proc_idx;
                            n_hit     = ram_rdata;
                            n_pend    = 1'b0;
                            n_state   = S_DONE;
                        end else if (last) begin
                            n_pend  = 1'b0;
                            n_state = S_DONE;
                        end
                    end else begin
                        if (hit) begin
                            n_found = 1'b1;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_wr_idx[IW-1:0];
                            ram_wdata = ram_rdata;
                            n_wr_idx  = r_wr_idx + CW'(1);
                        end
                        if (last) begin
                            n_count = hit ? r_wr_idx : r_wr_idx + CW'(1);
                            n_pend  = 1'b0;
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out.found       = r_found;
                    n_out.table_full  = r_full;
                    n_out.match_index = INDEX_W'(r_hit_idx);
                    n_out.match       = r_hit;
                    n_out.entry_count = COUNT_W'(r_count);
                    n_out_vld         = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.found         = r_out.found;
    assign o_rsp.table_full    = r_out.table_full;
    assign o_rsp.match_index   = r_out.match_index;
    assign o_rsp.match_network = r_out.match.network;
    assign o_rsp.match_prefix  = r_out.match.prefix;
    assign o_rsp.match_handle  = r_out.match.handle;
    assign o_rsp.entry_count   = r_out.entry_count;

endmodule
`default_nettype wire

/* hdl/spmt_entry_ram.sv */
`default_nettype none
module spmt_entry_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  spmt_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output spmt_pkg::t_entry o_rdata
);
    import spmt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* hdl/spmt_match_unit.sv */
`default_nettype none
module spmt_match_unit (
    input  logic                    i_exact,
    input  logic [31:0]             i_key,
    input  spmt_pkg::t_entry        i_entry,
    output logic                    o_hit
);
    import spmt_pkg::*;

    logic [ADDR_W-1:0] mask;

    // A prefix of zero gives an empty mask and a prefix of 32 a full one.
    assign mask  = ~({ADDR_W{1'b1}} >> i_entry.prefix);
    assign o_hit = i_exact ? (i_key == i_entry.network)
                           : (((i_key ^ i_entry.network) & mask) == '0);

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import spmt_pkg::*;

    localparam int TABLE_SLOTS = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_MAX = 10;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    spmt_cmd_if cmd_if ();
    spmt_rsp_if rsp_if ();

    subnet_prefix_match_table #(
        .TABLE_DEPTH(TABLE_SLOTS)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    always #10 clk = ~clk;

    // Mirror of the subnet table, updated as each command beat is accepted.
    logic [ADDR_W-1:0]   mirror_net    [TABLE_SLOTS];
    logic [PREFIX_W-1:0] mirror_prefix [TABLE_SLOTS];
    logic [HANDLE_W-1:0] mirror_handle [TABLE_SLOTS];
    int                  mirror_count;

    t_result answers_due [$];
    logic [ADDR_W-1:0] net_pool [16];

    bit pacing;
    int rsp_hold;
    int cycle_count;
    int mismatches;
    int answers_seen;
    int n_add, n_full, n_delete, n_removed, n_lookup, n_hit, n_unused;

    function automatic int gap_length();
        if ($urandom_range(0, 99) < 10) begin
            return $urandom_range(12, 40);
        end
        return $urandom_range(1, 4);
    endfunction

    function automatic int sender_gap();
        if (!pacing || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return gap_length();
    endfunction

    function automatic logic [ADDR_W-1:0] subnet_mask(logic [PREFIX_W-1:0] plen);
        return ~(32'hFFFF_FFFF >> plen);
    endfunction

    function automatic logic [ADDR_W-1:0] address_in_entry(int idx);
        logic [ADDR_W-1:0] m;
        m = subnet_mask(mirror_prefix[idx]);
        return (mirror_net[idx] & m) | ($urandom & ~m);
    endfunction

    function automatic t_result compute_table_answer(logic [1:0] func, logic [ADDR_W-1:0] addr,
                                                     logic [PREFIX_W-1:0] plen,
                                                     logic [HANDLE_W-1:0] hdl);
        t_result ans;
        logic [ADDR_W-1:0] m;
        int wr;
        int i;
        ans = '0;
        if (func == FUNC_ADD) begin
            n_add++;
            if (mirror_count >= TABLE_SLOTS) begin
                ans.table_full = 1'b1;
                n_full++;
            end else begin
                mirror_net[mirror_count]    = addr;
                mirror_prefix[mirror_count] = (plen > PREFIX_MAX) ? PREFIX_MAX : plen;
                mirror_handle[mirror_count] = hdl;
                mirror_count++;
            end
        end else if (func == FUNC_DELETE) begin
            n_delete++;
            wr = 0;
            for (i = 0; i < mirror_count; i++) begin
                if (mirror_net[i] == addr) begin
                    ans.found = 1'b1;
                end else begin
                    mirror_net[wr]    = mirror_net[i];
                    mirror_prefix[wr] = mirror_prefix[i];
                    mirror_handle[wr] = mirror_handle[i];
                    wr++;
                end
            end
            if (ans.found) begin
                n_removed++;
            end
            mirror_count = wr;
        end else if (func == FUNC_LOOKUP) begin
            n_lookup++;
            for (i = 0; i < mirror_count; i++) begin
                m = subnet_mask(mirror_prefix[i]);
                if (!ans.found && ((addr & m) == (mirror_net[i] & m))) begin
                    ans.found         = 1'b1;
                    ans.match_index   = i[INDEX_W-1:0];
                    ans.match.network = mirror_net[i];
                    ans.match.prefix  = mirror_prefix[i];
                    ans.match.handle  = mirror_handle[i];
                end
            end
            if (ans.found) begin
                n_hit++;
            end
        end else begin
            n_unused++;
        end
        ans.entry_count = mirror_count[COUNT_W-1:0];
        return ans;
    endfunction

    // Sends one command beat; valid stays high when the next beat follows at once.
    task automatic send_cmd(input logic [1:0] func, input logic [ADDR_W-1:0] addr,
                            input logic [PREFIX_W-1:0] plen, input logic [HANDLE_W-1:0] hdl);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.func       <= func;
        cmd_if.address    <= addr;
        cmd_if.prefix_len <= plen;
        cmd_if.handle     <= hdl;
        if (gap > 0 || !cmd_if.valid) begin
            cmd_if.valid <= 1'b1;
        end
        do @(posedge clk); while (!cmd_if.ready);
        answers_due.push_back(compute_table_answer(func, addr, plen, hdl));
    endtask

    task automatic wait_all_answered();
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (answers_due.size() != 0);
    endtask

    task automatic test_directed();
        send_cmd(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0000);
        send_cmd(FUNC_DELETE, 32'h0000_0000, 6'd63, 16'hFFFF);
        send_cmd(FUNC_UNUSED, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
        send_cmd(FUNC_ADD, 32'h0A00_0000, 6'd8, 16'h0001);
        send_cmd(FUNC_ADD, 32'h0A01_0000, 6'd16, 16'h0002);
        send_cmd(FUNC_ADD, 32'hC0A8_0101, 6'd32, 16'hFFFF);
        send_cmd(FUNC_ADD, 32'hFFFF_FFFF, 6'd63, 16'h8001);
        send_cmd(FUNC_ADD, 32'hAC10_0000, 6'd33, 16'h7FFE);
        send_cmd(FUNC_ADD, 32'h0000_0000, 6'd0, 16'h0000);
        send_cmd(FUNC_LOOKUP, 32'h0A01_0203, 6'd0, 16'h0000);
        send_cmd(FUNC_LOOKUP, 32'hC0A8_0101, 6'd0, 16'h0000);
        send_cmd(FUNC_LOOKUP, 32'hC0A8_0102, 6'd0, 16'h0000);
        send_cmd(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
        send_cmd(FUNC_LOOKUP, 32'hAC10_0001, 6'd0, 16'h0000);
        send_cmd(FUNC_DELETE, 32'h0A00_0000, 6'd0, 16'h0000);
        send_cmd(FUNC_LOOKUP, 32'h0A01_0203, 6'd0, 16'h0000);
        send_cmd(FUNC_ADD, 32'h0A01_0000, 6'd24, 16'h1234);
        send_cmd(FUNC_DELETE, 32'h0A01_0000, 6'd0, 16'h0000);
        send_cmd(FUNC_DELETE, 32'h0A01_0000, 6'd0, 16'h0000);
        send_cmd(FUNC_DELETE, 32'h0000_0000, 6'd0, 16'h0000);
        send_cmd(FUNC_LOOKUP, 32'h1234_5678, 6'd0, 16'h0000);
        send_cmd(FUNC_UNUSED, $urandom, 6'($urandom), 16'($urandom));
        wait_all_answered();
    endtask

    task automatic test_full_table();
        logic [ADDR_W-1:0] last_net;
        while (mirror_count < TABLE_SLOTS) begin
            last_net = $urandom;
            send_cmd(FUNC_ADD, last_net, 6'd32, 16'($urandom));
        end
        repeat (3) send_cmd(FUNC_ADD, $urandom, 6'($urandom), 16'($urandom));
        send_cmd(FUNC_LOOKUP, last_net, 6'($urandom), 16'($urandom));
        send_cmd(FUNC_LOOKUP, $urandom, 6'($urandom), 16'($urandom));
        send_cmd(FUNC_UNUSED, $urandom, 6'($urandom), 16'($urandom));
        wait_all_answered();
    endtask

    task automatic test_drain_table();
        while (mirror_count > 0) begin
            if ($urandom_range(0, 3) == 0) begin
                send_cmd(FUNC_LOOKUP, address_in_entry($urandom_range(0, mirror_count - 1)),
                         6'($urandom), 16'($urandom));
            end
            send_cmd(FUNC_DELETE, mirror_net[$urandom_range(0, mirror_count - 1)],
                     6'($urandom), 16'($urandom));
        end
        send_cmd(FUNC_DELETE, $urandom, 6'($urandom), 16'($urandom));
        send_cmd(FUNC_LOOKUP, $urandom, 6'($urandom), 16'($urandom));
        wait_all_answered();
    endtask

    task automatic test_random_mix(input int n_items);
        int r;
        int add_limit;
        logic [ADDR_W-1:0] addr;
        logic [PREFIX_W-1:0] plen;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            add_limit = (mirror_count > 56) ? 20 : 40;
            if (r < add_limit) begin
                addr = ($urandom_range(0, 3) == 0) ? net_pool[$urandom_range(0, 15)] : $urandom;
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    plen = 6'd0;
                end else if (r < 12) begin
                    plen = 6'($urandom_range(33, 63));
                end else begin
                    plen = 6'($urandom_range(1, 32));
                end
                send_cmd(FUNC_ADD, addr, plen, 16'($urandom));
            end else if (r < add_limit + 20) begin
                if (mirror_count > 0 && $urandom_range(0, 9) < 7) begin
                    addr = mirror_net[$urandom_range(0, mirror_count - 1)];
                end else begin
                    addr = $urandom;
                end
                send_cmd(FUNC_DELETE, addr, 6'($urandom), 16'($urandom));
            end else if (r < 96) begin
                if (mirror_count > 0 && $urandom_range(0, 9) < 7) begin
                    addr = address_in_entry($urandom_range(0, mirror_count - 1));
                end else begin
                    addr = $urandom;
                end
                send_cmd(FUNC_LOOKUP, addr, 6'($urandom), 16'($urandom));
            end else begin
                send_cmd(FUNC_UNUSED, $urandom, 6'($urandom), 16'($urandom));
            end
        end
        wait_all_answered();
    endtask

    always @(posedge clk) begin
        if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
            if (pacing && $urandom_range(0, 3) == 0) begin
                rsp_hold = gap_length();
            end
        end
    end

    always @(posedge clk) begin
        t_result got;
        t_result exp;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got.found         = rsp_if.found;
            got.table_full    = rsp_if.table_full;
            got.match_index   = rsp_if.match_index;
            got.match.network = rsp_if.match_network;
            got.match.prefix  = rsp_if.match_prefix;
            got.match.handle  = rsp_if.match_handle;
            got.entry_count   = rsp_if.entry_count;
            answers_seen++;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("Unexpected result beat %0d: %p", answers_seen, got);
                end
            end else begin
                exp = answers_due.pop_front();
                if (got.found !== exp.found || got.table_full !== exp.table_full
                        || got.match_index !== exp.match_index
                        || got.match.network !== exp.match.network
                        || got.match.prefix !== exp.match.prefix
                        || got.match.handle !== exp.match.handle
                        || got.entry_count !== exp.entry_count) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("Result beat %0d differs:", answers_seen);
                        $display("  expected found=%0b full=%0b idx=%0d net=%h pre=%0d hdl=%h cnt=%0d",
                                 exp.found, exp.table_full, exp.match_index, exp.match.network,
                                 exp.match.prefix, exp.match.handle, exp.entry_count);
                        $display("  actual   found=%0b full=%0b idx=%0d net=%h pre=%0d hdl=%h cnt=%0d",
                                 got.found, got.table_full, got.match_index, got.match.network,
                                 got.match.prefix, got.match.handle, got.entry_count);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out with %0d results outstanding.", answers_due.size());
            $display("FAIL subnet_prefix_match_table");
            $finish;
        end
    end

    initial begin
        rst_n             = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.func       = FUNC_ADD;
        cmd_if.address    = '0;
        cmd_if.prefix_len = '0;
        cmd_if.handle     = '0;
        rsp_if.ready      = 1'b0;
        pacing            = 1'b1;
        mirror_count      = 0;
        foreach (net_pool[i]) begin
            net_pool[i] = $urandom;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_drain_table();
        test_random_mix(600);
        pacing = 1'b0;
        test_random_mix(300);

        repeat (TABLE_SLOTS + 8) @(posedge clk);
        $display("Ran %0d adds (%0d refused as full), %0d deletes (%0d removing entries),",
                 n_add, n_full, n_delete, n_removed);
        $display("%0d lookups (%0d hits) and %0d unused codes; %0d results, %0d mismatches.",
                 n_lookup, n_hit, n_unused, answers_seen, mismatches);
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("PASS subnet_prefix_match_table");
        end else begin
            $display("%0d results never arrived.", answers_due.size());
            $display("FAIL subnet_prefix_match_table");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
hdl/spmt_pkg.sv
hdl/spmt_cmd_if.sv
hdl/spmt_rsp_if.sv
hdl/spmt_entry_ram.sv
hdl/spmt_match_unit.sv
hdl/subnet_prefix_match_table.sv
verif/tb.sv
